// ----- rtl/tpq_pkg.sv -----
// tpq_pkg: shared types, constants and helpers for the task pool ready queue
// used by the controller, the datapath, the top level and the port checker
// no dependencies
package tpq_pkg;

	// pool geometry
	localparam int SLOT_COUNT = 16;
	localparam int IDLE_ID    = 0;
	localparam int ID_W       = 4;
	localparam int LNK_W      = $clog2(SLOT_COUNT + 1);
	localparam int CNT_W      = $clog2(SLOT_COUNT);
	localparam logic [LNK_W-1:0] NUL = LNK_W'(SLOT_COUNT);

	// stream widths
	localparam int CMD_W  = 2;
	localparam int STAT_W = 3;
	localparam int IN_W   = 8;
	localparam int OUT_W  = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 2'd0,
		CMD_PICK    = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_DESTROY = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_FREE    = 3'd1,
		ST_BAD_ID     = 3'd2,
		ST_NOT_ALLOC  = 3'd3,
		ST_NOT_QUEUED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SS_FREE  = 2'd0,
		SS_READY = 2'd1,
		SS_RUN   = 2'd2
	} slot_st_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CREATE_POP,
		OP_APPEND,
		OP_PICK,
		OP_CHECK,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_WALK_CUT,
		OP_FREE,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CREATE,
		S_APPEND,
		S_PICK,
		S_CHECK,
		S_WSTART,
		S_WSTEP,
		S_WCUT,
		S_FREE,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic tid_bad;
		logic tid_idle;
		logic slot_free;
		logic fh_null;
		logic qh_null;
		logic qt_null;
		logic head_hit;
		logic lnk_null;
		logic lnk_hit;
		logic cnt_last;
		logic out_busy;
	} dp_stat_t;

	// any link at or above the slot count reads as null
	function automatic logic [LNK_W-1:0] norm(input logic [LNK_W-1:0] v);
		return (v < NUL) ? v : NUL;
	endfunction

endpackage

// ----- rtl/tpq_datapath.sv -----
// tpq_datapath: link store, slot states, list pointers, result and output registers
// performs one operation per cycle as ordered by tpq_ctrl
// depends on tpq_pkg
module tpq_datapath
	import tpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [OUT_W-1:0] m_tdata,
	input  ctl_cmd_t         cmd,
	output dp_stat_t         stat
);

	logic [LNK_W-1:0]  link_q [SLOT_COUNT];
	slot_st_t          slot_q [SLOT_COUNT];
	logic [LNK_W-1:0]  fh_q, qh_q, qt_q;
	logic [ID_W-1:0]   cur_q;
	cmd_t              cmd_q;
	logic [ID_W-1:0]   tid_q;
	logic [ID_W-1:0]   prev_q;
	logic [CNT_W-1:0]  cnt_q;
	status_t           stat_q;
	logic [ID_W-1:0]   rid_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [ID_W-1:0]   lnk_addr;
	logic [ID_W-1:0]   st_addr;
	logic [LNK_W-1:0]  lnk;
	slot_st_t          st_rd;
	logic [ID_W-1:0]   nx;
	logic              is_remove;
	logic              is_destroy;

	// single read port on each store
	always_comb begin
		unique case (cmd.op)
			OP_CREATE_POP: lnk_addr = fh_q[ID_W-1:0];
			OP_PICK:       lnk_addr = qh_q[ID_W-1:0];
			OP_WALK_STEP:  lnk_addr = prev_q;
			default:       lnk_addr = tid_q;
		endcase
		st_addr = (cmd.op == OP_PICK) ? cur_q : tid_q;
	end

	assign lnk        = norm(link_q[lnk_addr]);
	assign st_rd      = slot_q[st_addr];
	assign is_remove  = (cmd_q == CMD_REMOVE);
	assign is_destroy = (cmd_q == CMD_DESTROY);
	assign nx         = (qh_q == NUL) ? ID_W'(IDLE_ID) : qh_q[ID_W-1:0];

	// status toward the controller
	always_comb begin
		stat.cmd       = cmd_q;
		stat.tid_bad   = (LNK_W'(tid_q) >= NUL);
		stat.tid_idle  = (tid_q == ID_W'(IDLE_ID));
		stat.slot_free = (st_rd == SS_FREE);
		stat.fh_null   = (fh_q == NUL);
		stat.qh_null   = (qh_q == NUL);
		stat.qt_null   = (qt_q == NUL);
		stat.head_hit  = (qh_q == LNK_W'(tid_q));
		stat.lnk_null  = (lnk == NUL);
		stat.lnk_hit   = (lnk == LNK_W'(tid_q));
		stat.cnt_last  = (cnt_q == CNT_W'(SLOT_COUNT - 1));
		stat.out_busy  = out_valid_q && !m_tready;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				link_q[i] <= (i == IDLE_ID) ? NUL : LNK_W'(i + 1);
				slot_q[i] <= (i == IDLE_ID) ? SS_READY : SS_FREE;
			end
			fh_q        <= LNK_W'(1);
			qh_q        <= NUL;
			qt_q        <= NUL;
			cur_q       <= ID_W'(IDLE_ID);
			cmd_q       <= CMD_CREATE;
			tid_q       <= '0;
			prev_q      <= '0;
			cnt_q       <= '0;
			stat_q      <= ST_OK;
			rid_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (out_valid_q && m_tready && cmd.op != OP_PUBLISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_NONE: begin
				end
				OP_LOAD: begin
					cmd_q  <= cmd_t'(s_tdata[CMD_W-1:0]);
					tid_q  <= s_tdata[CMD_W +: ID_W];
					stat_q <= ST_OK;
					rid_q  <= '0;
				end
				// pop the free head and queue it if the queue is empty, or flag that no slot is free
				OP_CREATE_POP: begin
					if (fh_q == NUL) begin
						stat_q <= ST_NO_FREE;
					end else begin
						fh_q                    <= lnk;
						slot_q[fh_q[ID_W-1:0]]  <= SS_READY;
						link_q[fh_q[ID_W-1:0]]  <= NUL;
						rid_q                   <= fh_q[ID_W-1:0];
						if (qh_q == NUL || qt_q == NUL) begin
							qh_q <= fh_q;
							qt_q <= fh_q;
						end
					end
				end
				// hang the new slot behind the tail
				OP_APPEND: begin
					link_q[qt_q[ID_W-1:0]] <= LNK_W'(rid_q);
					qt_q                   <= LNK_W'(rid_q);
				end
				// pop the head or fall back to idle, swap running task
				OP_PICK: begin
					if (qh_q != NUL) begin
						qh_q <= lnk;
						if (lnk == NUL) begin
							qt_q <= NUL;
						end
					end
					if (cur_q != nx && cur_q != ID_W'(IDLE_ID) && st_rd == SS_RUN) begin
						slot_q[cur_q] <= SS_READY;
					end
					slot_q[nx] <= SS_RUN;
					cur_q      <= nx;
					rid_q      <= nx;
				end
				OP_CHECK: begin
					if (stat.tid_bad || (is_destroy && stat.tid_idle)) begin
						stat_q <= ST_BAD_ID;
					end else if (is_destroy && stat.slot_free) begin
						stat_q <= ST_NOT_ALLOC;
					end
				end
				// head of the walk: empty queue, head match or start scanning
				OP_WALK_START: begin
					if (qh_q == NUL) begin
						if (is_remove) begin
							stat_q <= ST_NOT_QUEUED;
						end
					end else if (qh_q == LNK_W'(tid_q)) begin
						qh_q <= lnk;
						if (lnk == NUL) begin
							qt_q <= NUL;
						end
					end else begin
						prev_q <= qh_q[ID_W-1:0];
						cnt_q  <= '0;
					end
				end
				// one link per cycle
				OP_WALK_STEP: begin
					if (stat.lnk_null || (!stat.lnk_hit && stat.cnt_last)) begin
						if (is_remove) begin
							stat_q <= ST_NOT_QUEUED;
						end
					end else if (!stat.lnk_hit) begin
						prev_q <= lnk[ID_W-1:0];
						cnt_q  <= cnt_q + CNT_W'(1);
					end
				end
				// bypass the matched slot
				OP_WALK_CUT: begin
					link_q[prev_q] <= lnk;
					if (qt_q == LNK_W'(tid_q)) begin
						qt_q <= LNK_W'(prev_q);
					end
				end
				OP_FREE: begin
					slot_q[tid_q] <= SS_FREE;
					link_q[tid_q] <= fh_q;
					fh_q          <= LNK_W'(tid_q);
				end
				OP_PUBLISH: begin
					out_valid_q <= 1'b1;
					out_data_q  <= {(qh_q == NUL), rid_q, stat_q};
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- rtl/tpq_ctrl.sv -----
// tpq_ctrl: sequencer for create, pick, remove and destroy
// orders one datapath operation per cycle from the datapath status
// depends on tpq_pkg
module tpq_ctrl
	import tpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  cmd_t     in_cmd,
	output logic     s_tready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	ctl_state_t walk_end;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// destroy frees the slot whether or not it was queued
	assign walk_end = (stat.cmd == CMD_DESTROY) ? S_FREE : S_DONE;

	// next state and datapath operation
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					unique case (in_cmd)
						CMD_CREATE: state_d = S_CREATE;
						CMD_PICK:   state_d = S_PICK;
						default:    state_d = S_CHECK;
					endcase
				end
			end
			S_CREATE: begin
				cmd.op  = OP_CREATE_POP;
				state_d = (!stat.fh_null && !stat.qh_null && !stat.qt_null) ? S_APPEND : S_DONE;
			end
			S_APPEND: begin
				cmd.op  = OP_APPEND;
				state_d = S_DONE;
			end
			S_PICK: begin
				cmd.op  = OP_PICK;
				state_d = S_DONE;
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				if (stat.tid_bad || (stat.cmd == CMD_DESTROY && (stat.tid_idle || stat.slot_free)))
				begin
					state_d = S_DONE;
				end else begin
					state_d = S_WSTART;
				end
			end
			S_WSTART: begin
				cmd.op  = OP_WALK_START;
				state_d = (stat.qh_null || stat.head_hit) ? walk_end : S_WSTEP;
			end
			S_WSTEP: begin
				cmd.op = OP_WALK_STEP;
				priority if (stat.lnk_null) begin
					state_d = walk_end;
				end else if (stat.lnk_hit) begin
					state_d = S_WCUT;
				end else if (stat.cnt_last) begin
					state_d = walk_end;
				end
			end
			S_WCUT: begin
				cmd.op  = OP_WALK_CUT;
				state_d = walk_end;
			end
			S_FREE: begin
				cmd.op  = OP_FREE;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/task_pool_fcfs_ready_queue_top.sv -----
// task pool with fcfs ready queue: one item in, one result item out
// create pops a free slot and pick pops the queue head; remove and destroy walk the ready
// queue one link per cycle, and destroy then frees the slot; a result waits while
// the previous one is still stalled at the output
// a new item can be taken from the cycle in which the previous result is first offered
// reset clears all state at once: slot 0 ready as idle task, free list 1 to 15, empty queue
module task_pool_fcfs_ready_queue_top
	import tpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // command[1:0], task_id[5:2], zero[7:6]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status[2:0], result_id[6:3], queue_empty[7]
);

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	// sequencer
	tpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_cmd   (cmd_t'(s_tdata[CMD_W-1:0])),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	// stores and pointers
	tpq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (ctl_cmd),
		.stat     (dp_stat)
	);

endmodule

// ----- rtl/tpq_checker.sv -----
// tpq_checker: port-level checks on the task pool top level
// bound to task_pool_fcfs_ready_queue_top, depends on tpq_pkg
module tpq_checker
	import tpq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// one item in flight: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready while an item is in flight");

	// status code is always a defined one
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[STAT_W-1:0] <= ST_NOT_QUEUED)
		else $error("undefined status code");

	// failed items carry a zero id
	a_fail_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STAT_W-1:0] != ST_OK |-> m_tdata[STAT_W +: ID_W] == '0)
		else $error("failed item with nonzero id");

	// input ready never comes alongside a stalled result right after an accept
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(m_tvalid && !m_tready && $past(s_tvalid && s_tready)))
		else $error("input accepted with result pending from previous item");

endmodule

bind task_pool_fcfs_ready_queue_top tpq_checker u_tpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- dv/task_pool_fcfs_ready_queue_top_tb.sv -----
// testbench for task_pool_fcfs_ready_queue_top: directed and random scheduler commands
// a tracker class predicts every result item and checks the stream out of the block
// depends on tpq_pkg and the top level only
`timescale 1ns / 100ps

module task_pool_fcfs_ready_queue_top_tb
	import tpq_pkg::*;
;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 650;

	// expected result item, fields as the block reports them
	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  rid;
		logic             empty;
	} sched_result_t;

	// shadow of the slot pool: free list, ready queue, slot states, running task
	class task_pool_tracker;
		slot_st_t            slot_st[SLOT_COUNT];
		logic [LNK_W-1:0]    link_mem[SLOT_COUNT];
		logic [LNK_W-1:0]    free_hd;
		logic [LNK_W-1:0]    q_hd;
		logic [LNK_W-1:0]    q_tl;
		logic [LNK_W-1:0]    cur_task;
		sched_result_t       due_replies[$];
		int                  errors;

		function new();
			for (int i = 0; i < SLOT_COUNT; i++) begin
				link_mem[i] = LNK_W'(i + 1);
				slot_st[i]  = SS_FREE;
			end
			link_mem[IDLE_ID] = NUL;
			slot_st[IDLE_ID]  = SS_READY;
			free_hd  = LNK_W'(1);
			q_hd     = NUL;
			q_tl     = NUL;
			cur_task = LNK_W'(IDLE_ID);
			errors   = 0;
		endfunction

		// take slot t out of the ready queue, walking at most SLOT_COUNT links
		function bit unlink_slot(logic [LNK_W-1:0] t);
			logic [LNK_W-1:0] prev;
			logic [LNK_W-1:0] nxt;
			if (q_hd == NUL)
				return 0;
			if (q_hd == t) begin
				q_hd = link_mem[t];
				if (q_hd == NUL)
					q_tl = NUL;
				return 1;
			end
			prev = q_hd;
			for (int n = 0; n < SLOT_COUNT; n++) begin
				nxt = link_mem[prev];
				if (nxt == NUL)
					return 0;
				if (nxt == t) begin
					link_mem[prev] = link_mem[t];
					if (q_tl == t)
						q_tl = prev;
					return 1;
				end
				prev = nxt;
			end
			return 0;
		endfunction

		// accepted command: update the shadow and queue the expected reply
		function void note_command(cmd_t cmd, logic [ID_W-1:0] tid);
			sched_result_t    r;
			logic [LNK_W-1:0] s;
			logic [LNK_W-1:0] nx;
			logic [LNK_W-1:0] pv;
			r.status = ST_OK;
			r.rid    = '0;
			s = LNK_W'(tid);
			case (cmd)
			CMD_CREATE: begin
				s = free_hd;
				if (s == NUL) begin
					r.status = ST_NO_FREE;
				end else begin
					free_hd     = link_mem[s];
					slot_st[s]  = SS_READY;
					link_mem[s] = NUL;
					if (q_hd == NUL || q_tl == NUL) begin
						q_hd = s;
						q_tl = s;
					end else begin
						link_mem[q_tl] = s;
						q_tl = s;
					end
					r.rid = s[ID_W-1:0];
				end
			end
			CMD_PICK: begin
				nx = q_hd;
				pv = cur_task;
				if (nx == NUL) begin
					nx = LNK_W'(IDLE_ID);
				end else begin
					q_hd = link_mem[nx];
					if (q_hd == NUL)
						q_tl = NUL;
				end
				// previous task goes back to ready, but is not queued again
				if (pv != nx && pv != IDLE_ID && slot_st[pv] == SS_RUN)
					slot_st[pv] = SS_READY;
				slot_st[nx] = SS_RUN;
				cur_task = nx;
				r.rid = nx[ID_W-1:0];
			end
			CMD_REMOVE: begin
				if (!unlink_slot(s))
					r.status = ST_NOT_QUEUED;
			end
			default: begin
				if (tid == IDLE_ID) begin
					r.status = ST_BAD_ID;
				end else if (slot_st[s] == SS_FREE) begin
					r.status = ST_NOT_ALLOC;
				end else begin
					void'(unlink_slot(s));
					slot_st[s]  = SS_FREE;
					link_mem[s] = free_hd;
					free_hd     = s;
				end
			end
			endcase
			r.empty = (q_hd == NUL);
			due_replies.push_back(r);
		endfunction

		// compare one result item with the oldest expected reply
		function void check_reply(logic [OUT_W-1:0] data);
			sched_result_t exp_r;
			if (due_replies.size() == 0) begin
				$display("%0t: result item with none expected, got %h", $time, data);
				errors++;
				return;
			end
			exp_r = due_replies.pop_front();
			if (data[2:0] !== exp_r.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d",
					$time, exp_r.status, data[2:0]);
				errors++;
			end
			if (data[6:3] !== exp_r.rid) begin
				$display("%0t: result_id mismatch, expected %0d, got %0d",
					$time, exp_r.rid, data[6:3]);
				errors++;
			end
			if (data[7] !== exp_r.empty) begin
				$display("%0t: queue_empty mismatch, expected %0d, got %0d",
					$time, exp_r.empty, data[7]);
				errors++;
			end
		endfunction

		function int pending();
			return due_replies.size();
		endfunction

		// mostly a slot in use, so remove and destroy reach deep states
		function logic [ID_W-1:0] busy_slot();
			logic [ID_W-1:0] used[$];
			for (int i = 0; i < SLOT_COUNT; i++)
				if (slot_st[i] != SS_FREE)
					used.push_back(ID_W'(i));
			if (used.size() == 0)
				return ID_W'($urandom_range(0, SLOT_COUNT - 1));
			return used[$urandom_range(0, used.size() - 1)];
		endfunction
	endclass

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	task_pool_tracker tracker = new();
	bit               no_idle = 1'b0;

	task_pool_fcfs_ready_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// gap length: mostly short, now and then long
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// offer one command and hold it until the block takes it
	task automatic push_item(input cmd_t cmd, input logic [ID_W-1:0] tid);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, tid, cmd};
		do @(posedge clk); while (!s_tready);
		tracker.note_command(cmd, tid);
	endtask

	// optional pause on the input side after an accepted item
	task automatic sender_gap();
		int n;
		n = 0;
		if (!no_idle && $urandom_range(0, 2) == 0)
			n = gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_directed(input cmd_t cmd, input int tid);
		push_item(cmd, ID_W'(tid));
		sender_gap();
	endtask

	// result side: random stalls plus one long hold-off to back up the input
	initial begin : result_sink
		int stall;
		int seen;
		bit held;
		stall = 0;
		seen  = 0;
		held  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				tracker.check_reply(m_tdata);
				seen++;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!held && seen == 120) begin
				held  = 1'b1;
				stall = 400;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				stall = gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int   roll;
		int   create_pct;
		int   destroy_pct;
		cmd_t cmd;
		logic [ID_W-1:0] tid;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle task picked while already current
		send_directed(CMD_PICK, 0);
		// fill the pool, then create with no free slot
		for (int i = 0; i < SLOT_COUNT; i++)
			send_directed(CMD_CREATE, 15 - i);
		// unlink tail, head and a middle slot, then one no longer queued
		send_directed(CMD_REMOVE, 15);
		send_directed(CMD_REMOVE, 1);
		send_directed(CMD_REMOVE, 7);
		send_directed(CMD_REMOVE, 7);
		// idle id cannot be destroyed
		send_directed(CMD_DESTROY, 0);
		// destroy the running task, then pick past it
		send_directed(CMD_PICK, 0);
		send_directed(CMD_DESTROY, 2);
		send_directed(CMD_PICK, 0);
		// ready but unqueued slot, then the same slot once free
		send_directed(CMD_DESTROY, 1);
		send_directed(CMD_DESTROY, 1);
		// slot still in the ready queue
		send_directed(CMD_DESTROY, 8);

		// random part: phases that fill and drain the pool
		create_pct  = 45;
		destroy_pct = 15;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 50 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				if ((k / 50) % 2 == 0) begin
					create_pct  = 45;
					destroy_pct = 15;
				end else begin
					create_pct  = 15;
					destroy_pct = 45;
				end
			end
			roll = $urandom_range(0, 99);
			if (roll < create_pct)
				cmd = CMD_CREATE;
			else if (roll < create_pct + 25)
				cmd = CMD_PICK;
			else if (roll < 100 - destroy_pct)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_DESTROY;
			if ($urandom_range(0, 3) == 0)
				tid = ID_W'($urandom_range(0, SLOT_COUNT - 1));
			else
				tid = tracker.busy_slot();
			push_item(cmd, tid);
			sender_gap();
		end
		s_tvalid <= 1'b0;

		// drain, then watch for stray result items
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (3 * SLOT_COUNT) @(posedge clk);
		if (tracker.pending() > 0) begin
			$display("%0t: %0d expected result items never arrived", $time, tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
